@@ src/cirf_pkg.sv @@
// Shared types and constants of the CAN identifier rate filter.
// Used by cirf_slot_mem, cirf_slot_update and can_id_rate_filter; depends on nothing.
`default_nettype none

package cirf_pkg;

    localparam int C_SLOT_COUNT = 2048;  // default number of slots
    localparam int C_ID_LIMIT   = 2048;  // first identifier outside the 11-bit range
    localparam int C_MAX_LEN    = 8;     // CAN classic payload bytes

    typedef enum logic [1:0] {
        MODE_NEVER  = 2'd0,
        MODE_ALWAYS = 2'd1,
        MODE_TIMED  = 2'd2,
        MODE_COUNT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DROPPED   = 2'd0,
        STAT_FORWARDED = 2'd1,
        STAT_BAD_ID    = 2'd2,
        STAT_WRITTEN   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE
    } t_state;

    // One slot table entry.
    typedef struct packed {
        t_mode        mode;
        logic [15:0]  period;
        logic [15:0]  count;
        logic [31:0]  last_time;
        logic [15:0]  skip;
    } t_slot;

    // Decision for one transaction: write-back request plus the result fields.
    typedef struct packed {
        logic         wr_en;
        t_slot        slot;
        t_status      status;
        logic [10:0]  id;
        logic         rtr;
        logic [3:0]   len;
        logic [63:0]  payload;
    } t_verdict;

endpackage

`default_nettype wire

@@ src/cirf_slot_mem.sv @@
// Slot table: single write port, single read port with registered read data.
// Depends on cirf_pkg for the slot entry type.
`default_nettype none

module cirf_slot_mem
    import cirf_pkg::*;
#(
    parameter int DEPTH = C_SLOT_COUNT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_slot                         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire t_slot                    i_wr_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ src/cirf_slot_update.sv @@
// Per-transaction decision: forward or drop, and the updated slot entry.
// Depends on cirf_pkg for modes, status codes and the verdict struct.
`default_nettype none

module cirf_slot_update
    import cirf_pkg::*;
(
    input  wire logic        i_bad,
    input  wire logic        i_command,
    input  wire logic [10:0] i_id,
    input  wire logic        i_rtr,
    input  wire logic [3:0]  i_len,
    input  wire logic [63:0] i_payload,
    input  wire logic [31:0] i_now,
    input  wire logic [1:0]  i_new_mode,
    input  wire logic [15:0] i_new_period,
    input  wire logic [15:0] i_new_count,
    input  wire t_slot       i_slot,
    output t_verdict         o_verdict
);

    logic [3:0]  len_sat;
    logic [31:0] elapsed;
    logic [15:0] skip_inc;
    logic [63:0] masked;
    logic        fwd;

    assign len_sat  = (i_len > 4'(C_MAX_LEN)) ? 4'(C_MAX_LEN) : i_len;
    assign elapsed  = i_now - i_slot.last_time;
    assign skip_inc = i_slot.skip + 16'd1;

    // Zero the bytes beyond the frame length.
    always_comb begin
        for (int k = 0; k < C_MAX_LEN; k++) begin
            masked[8*k +: 8] = (4'(k) < len_sat) ? i_payload[8*k +: 8] : 8'd0;
        end
    end

    always_comb begin
        o_verdict      = '0;
        o_verdict.slot = i_slot;
        fwd            = 1'b0;
        if (i_bad) begin
            o_verdict.status = STAT_BAD_ID;
        end else if (i_command) begin
            o_verdict.wr_en          = 1'b1;
            o_verdict.slot.mode      = t_mode'(i_new_mode);
            o_verdict.slot.period    = i_new_period;
            o_verdict.slot.count     = i_new_count;
            o_verdict.slot.last_time = '0;
            o_verdict.slot.skip      = '0;
            o_verdict.status         = STAT_WRITTEN;
        end else begin
            case (i_slot.mode)
                MODE_ALWAYS: begin
                    fwd = 1'b1;
                end
                MODE_TIMED: begin
                    if (elapsed > {16'd0, i_slot.period}) begin
                        fwd                      = 1'b1;
                        o_verdict.wr_en          = 1'b1;
                        o_verdict.slot.last_time = i_now;
                    end
                end
                MODE_COUNT: begin
                    o_verdict.wr_en = 1'b1;
                    if (skip_inc >= i_slot.count) begin
                        fwd                 = 1'b1;
                        o_verdict.slot.skip = '0;
                    end else begin
                        o_verdict.slot.skip = skip_inc;
                    end
                end
                default: begin
                    fwd = 1'b0;
                end
            endcase
            if (fwd) begin
                o_verdict.status  = STAT_FORWARDED;
                o_verdict.id      = i_id;
                o_verdict.rtr     = i_rtr;
                o_verdict.len     = len_sat;
                o_verdict.payload = masked;
            end else begin
                o_verdict.status = STAT_DROPPED;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/can_id_rate_filter.sv @@
// Top level of the CAN identifier rate filter: control sequencer, item and result registers.
// Depends on cirf_pkg, cirf_slot_mem and cirf_slot_update.
`default_nettype none

// CAN identifier rate filter. Each input transaction is either a received CAN frame
// (i_command = 0) or a slot write (i_command = 1) for slot i_msg_id; every transaction
// yields exactly one result transaction with a status: dropped, forwarded, bad identifier
// (identifier of 2048 or more, or beyond SLOT_COUNT) or slot written. Only forwarded
// results carry the frame fields; all other results show them as zero. The slot table is
// one synchronous memory of SLOT_COUNT entries with registered read data. The accept
// edge issues the slot read; in the decide state, as soon as the result register is
// free, the updated slot is written back and the result register is loaded. One
// read-modify-write is in flight at a time, so no two accesses to the same slot
// overlap. The next transaction is taken as soon as the previous one sits in the result
// register, even while that result is still stalled; a stalled result holds the
// sequencer only when a second result is ready. After reset the table is cleared one
// entry per cycle, during which o_in_stall stays high.
module can_id_rate_filter
    import cirf_pkg::*;
#(
    parameter int SLOT_COUNT = C_SLOT_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [15:0] i_msg_id,
    input  wire logic        i_remote_request,
    input  wire logic [3:0]  i_data_length,
    input  wire logic [63:0] i_payload,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [1:0]  i_new_mode,
    input  wire logic [15:0] i_new_period_ms,
    input  wire logic [15:0] i_new_count,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [10:0]      o_out_id,
    output logic             o_out_rtr,
    output logic [3:0]       o_out_length,
    output logic [63:0]      o_out_payload
);

    localparam int AW       = $clog2(SLOT_COUNT);
    // Identifiers at or above this value are rejected.
    localparam int IdLimit  = (SLOT_COUNT < C_ID_LIMIT) ? SLOT_COUNT : C_ID_LIMIT;

    t_state      r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    // Captured transaction.
    logic        r_bad;
    logic        r_command;
    logic [15:0] r_msg_id;
    logic        r_rtr;
    logic [3:0]  r_len;
    logic [63:0] r_payload;
    logic [31:0] r_now;
    logic [1:0]  r_new_mode;
    logic [15:0] r_new_period;
    logic [15:0] r_new_count;

    // Result register.
    logic        r_out_valid;
    t_status     r_status;
    logic [10:0] r_out_id;
    logic        r_out_rtr;
    logic [3:0]  r_out_len;
    logic [63:0] r_out_payload;

    logic        in_accept;
    logic        out_free;
    logic        finish;
    logic        clr_last;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    t_slot         mem_wr_data;
    t_slot         rd_slot;
    t_verdict      verdict;

    // Result slot is free if empty or being drained at this edge.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;
    assign clr_last  = (r_clr_addr == AW'(SLOT_COUNT - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Control outputs: input stall and the write-port source.
    always_comb begin
        o_in_stall  = 1'b1;
        finish      = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_msg_id[AW-1:0];
        mem_wr_data = verdict.slot;
        case (r_state)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                mem_wr_data = '0;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_DECIDE: begin
                finish    = out_free;
                mem_wr_en = out_free && verdict.wr_en;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // Set on a new result, drop when the current one is taken.
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the accepted transaction for the decide state.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_bad        <= (i_msg_id >= 16'(IdLimit));
            r_command    <= i_command;
            r_msg_id     <= i_msg_id;
            r_rtr        <= i_remote_request;
            r_len        <= i_data_length;
            r_payload    <= i_payload;
            r_now        <= i_now_ms;
            r_new_mode   <= i_new_mode;
            r_new_period <= i_new_period_ms;
            r_new_count  <= i_new_count;
        end
    end

    // Load the result register when the decision completes.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status      <= verdict.status;
            r_out_id      <= verdict.id;
            r_out_rtr     <= verdict.rtr;
            r_out_len     <= verdict.len;
            r_out_payload <= verdict.payload;
        end
    end

    cirf_slot_mem #(
        .DEPTH (SLOT_COUNT)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_msg_id[AW-1:0]),
        .o_rd_data (rd_slot),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    cirf_slot_update u_slot_update (
        .i_bad        (r_bad),
        .i_command    (r_command),
        .i_id         (r_msg_id[10:0]),
        .i_rtr        (r_rtr),
        .i_len        (r_len),
        .i_payload    (r_payload),
        .i_now        (r_now),
        .i_new_mode   (r_new_mode),
        .i_new_period (r_new_period),
        .i_new_count  (r_new_count),
        .i_slot       (rd_slot),
        .o_verdict    (verdict)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_id      = r_out_id;
    assign o_out_rtr     = r_out_rtr;
    assign o_out_length  = r_out_len;
    assign o_out_payload = r_out_payload;

`ifndef SYNTHESIS
    // An accepted transaction always goes on to its decide cycle.
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_DECIDE))
        else $error("accepted transaction did not reach decide");

    // A new result appears only out of a decide cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DECIDE))
        else $error("result appeared without a decision");

    // The slot table is written only by the clearing sweep or a completing decision.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> ((r_state == ST_CLEAR) || finish))
        else $error("unexpected slot table write");

    // Bad identifiers never touch the table.
    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DECIDE) && r_bad) |-> !mem_wr_en)
        else $error("slot written for a bad identifier");

    // Only forwarded results carry frame fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_FORWARDED)) |->
            ((o_out_payload == '0) && (o_out_length == '0) && (o_out_id == '0)))
        else $error("frame fields on a non-forward result");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for can_id_rate_filter: directed and random frames and slot writes.
// Depends on cirf_pkg and can_id_rate_filter; a scoreboard class keeps its own copy of the
// slot table.
`timescale 1ns / 100ps

module tb_top;
    import cirf_pkg::*;

    localparam logic CMD_FRAME      = 1'b0;
    localparam logic CMD_SLOT_WRITE = 1'b1;
    localparam int   RANDOM_ITEMS   = 480;
    localparam int   HOLD_CYCLES    = 400;   // long output hold-off that backs up the block
    localparam int   DRAIN_CYCLES   = 8;     // idle margin after the drain

    // One input transaction, field for field as on the ports.
    typedef struct {
        logic        command;
        logic [15:0] msg_id;
        logic        rtr;
        logic [3:0]  length;
        logic [63:0] payload;
        logic [31:0] now_ms;
        t_mode       mode;
        logic [15:0] period;
        logic [15:0] count;
    } t_item;

    // One result transaction.
    typedef struct packed {
        t_status     status;
        logic [10:0] id;
        logic        rtr;
        logic [3:0]  length;
        logic [63:0] payload;
    } t_result;

    // Scoreboard: own copy of the slot table, predicts each result at input acceptance.
    class filter_scoreboard;
        t_mode       mode_tbl[C_SLOT_COUNT];
        logic [15:0] period_tbl[C_SLOT_COUNT];
        logic [15:0] count_tbl[C_SLOT_COUNT];
        logic [31:0] last_fwd_tbl[C_SLOT_COUNT];
        logic [15:0] skip_tbl[C_SLOT_COUNT];
        t_result     pending_results[$];
        int          error_count;
        int          status_seen[4];

        function new();
            foreach (mode_tbl[s]) begin
                mode_tbl[s]     = MODE_NEVER;
                period_tbl[s]   = '0;
                count_tbl[s]    = '0;
                last_fwd_tbl[s] = '0;
                skip_tbl[s]     = '0;
            end
            error_count = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the slot table by one accepted transaction and queue its result.
        function void note_item(t_item it);
            t_result     want;
            logic [31:0] elapsed;
            logic [3:0]  len;
            logic [63:0] mask;
            bit          fwd;
            int          s;
            want = '0;
            fwd  = 0;
            if (it.msg_id >= C_ID_LIMIT) begin
                want.status = STAT_BAD_ID;
            end else begin
                s = it.msg_id;
                if (it.command == CMD_SLOT_WRITE) begin
                    mode_tbl[s]     = it.mode;
                    period_tbl[s]   = it.period;
                    count_tbl[s]    = it.count;
                    last_fwd_tbl[s] = '0;
                    skip_tbl[s]     = '0;
                    want.status     = STAT_WRITTEN;
                end else begin
                    case (mode_tbl[s])
                        MODE_ALWAYS: fwd = 1;
                        MODE_TIMED: begin
                            elapsed = it.now_ms - last_fwd_tbl[s];
                            if (elapsed > {16'd0, period_tbl[s]}) begin
                                last_fwd_tbl[s] = it.now_ms;
                                fwd = 1;
                            end
                        end
                        MODE_COUNT: begin
                            skip_tbl[s] = skip_tbl[s] + 16'd1;
                            if (skip_tbl[s] >= count_tbl[s]) begin
                                skip_tbl[s] = '0;
                                fwd = 1;
                            end
                        end
                        default: ;
                    endcase
                    if (fwd) begin
                        len  = (it.length > C_MAX_LEN) ? 4'(C_MAX_LEN) : it.length;
                        mask = (len == C_MAX_LEN) ? '1 : ((64'd1 << (int'(len) * 8)) - 64'd1);
                        want.status  = STAT_FORWARDED;
                        want.id      = it.msg_id[10:0];
                        want.rtr     = it.rtr;
                        want.length  = len;
                        want.payload = it.payload & mask;
                    end else begin
                        want.status = STAT_DROPPED;
                    end
                end
            end
            pending_results.push_back(want);
        endfunction

        function void report(string what, t_result want, t_result got);
            error_count++;
            if (error_count <= 10)
                $display("%0t ERROR %s: expected st=%0d id=%0d rtr=%0b len=%0d data=%h, got st=%0d id=%0d rtr=%0b len=%0d data=%h",
                         $time, what, want.status, want.id, want.rtr, want.length, want.payload,
                         got.status, got.id, got.rtr, got.length, got.payload);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("result with nothing outstanding", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.id !== want.id || got.rtr !== want.rtr ||
                got.length !== want.length || got.payload !== want.payload)
                report("result mismatch", want, got);
            else
                status_seen[want.status]++;
        endfunction
    endclass

    // DUT ports; every input starts at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = CMD_FRAME;
    logic [15:0] i_msg_id = '0;
    logic        i_remote_request = 1'b0;
    logic [3:0]  i_data_length = '0;
    logic [63:0] i_payload = '0;
    logic [31:0] i_now_ms = '0;
    logic [1:0]  i_new_mode = '0;
    logic [15:0] i_new_period_ms = '0;
    logic [15:0] i_new_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [10:0] o_out_id;
    logic        o_out_rtr;
    logic [3:0]  o_out_length;
    logic [63:0] o_out_payload;

    filter_scoreboard sb;

    // Traffic shaping, set by the stimulus thread per phase.
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_req_seq = 0;   // bump to request one long output hold-off
    int          hold_seen_seq = 0;
    int          hold_left = 0;

    // Stimulus-side state for random frames.
    logic [31:0] clock_ms = '0;
    logic [15:0] hot_ids[8];

    can_id_rate_filter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_msg_id         (i_msg_id),
        .i_remote_request (i_remote_request),
        .i_data_length    (i_data_length),
        .i_payload        (i_payload),
        .i_now_ms         (i_now_ms),
        .i_new_mode       (i_new_mode),
        .i_new_period_ms  (i_new_period_ms),
        .i_new_count      (i_new_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_out_id         (o_out_id),
        .o_out_rtr        (o_out_rtr),
        .o_out_length     (o_out_length),
        .o_out_payload    (o_out_payload)
    );

    always #5 i_clk = ~i_clk;

    // Receiver stall: honor a hold-off request first, counted here in cycles,
    // otherwise stall at random at the current phase's rate.
    always @(posedge i_clk) begin
        if (hold_req_seq != hold_seen_seq) begin
            hold_seen_seq <= hold_req_seq;
            hold_left     <= HOLD_CYCLES - 1;
            i_out_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result monitor: a transaction completes when valid is high and stall is low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{t_status'(o_status), o_out_id, o_out_rtr, o_out_length,
                              o_out_payload});
    end

    // Frame transaction; slot-write fields carry noise that the block must ignore.
    function automatic t_item make_frame(logic [15:0] id, logic [31:0] now_ms, logic rtr,
                                         logic [3:0] length, logic [63:0] payload);
        t_item it;
        it.command = CMD_FRAME;
        it.msg_id  = id;
        it.rtr     = rtr;
        it.length  = length;
        it.payload = payload;
        it.now_ms  = now_ms;
        it.mode    = t_mode'($urandom_range(0, 3));
        it.period  = 16'($urandom);
        it.count   = 16'($urandom);
        return it;
    endfunction

    // Slot-write transaction; frame fields carry noise.
    function automatic t_item make_slot_write(logic [15:0] id, t_mode mode,
                                              logic [15:0] period, logic [15:0] count);
        t_item it;
        it.command = CMD_SLOT_WRITE;
        it.msg_id  = id;
        it.rtr     = 1'($urandom);
        it.length  = 4'($urandom);
        it.payload = {$urandom, $urandom};
        it.now_ms  = $urandom;
        it.mode    = mode;
        it.period  = period;
        it.count   = count;
        return it;
    endfunction

    // Random transaction: mostly frames to a few hot slots with small periods and counts,
    // so timed and count decisions flip often; some slot rewrites, stray slots and bad IDs.
    function automatic t_item random_item();
        int          pick;
        logic [15:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            id = 16'($urandom_range(C_ID_LIMIT, 65535));
        else if (pick < 15)
            id = 16'($urandom_range(0, C_ID_LIMIT - 1));
        else
            id = hot_ids[$urandom_range(0, 7)];
        if ($urandom_range(0, 99) < 12)
            return make_slot_write(id, t_mode'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
        // Advance time in small steps, with an occasional jump anywhere on the clock.
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + 32'($urandom_range(0, 25));
        return make_frame(id, clock_ms, 1'($urandom), 4'($urandom_range(0, 15)),
                          {$urandom, $urandom});
    endfunction

    // Offer one transaction after a random gap and hold it until accepted.
    task automatic drive_item(t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= it.command;
        i_msg_id         <= it.msg_id;
        i_remote_request <= it.rtr;
        i_data_length    <= it.length;
        i_payload        <= it.payload;
        i_now_ms         <= it.now_ms;
        i_new_mode       <= it.mode;
        i_new_period_ms  <= it.period;
        i_new_count      <= it.count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(it);
    endtask

    // Put every hot slot into a forwarding mode so random frames reach the decision logic.
    task automatic program_hot_slots();
        foreach (hot_ids[k])
            drive_item(make_slot_write(hot_ids[k], t_mode'($urandom_range(1, 3)),
                                       16'($urandom_range(0, 30)), 16'($urandom_range(0, 5))));
    endtask

    initial begin
        int idle_send[4];
        int idle_stall[4];
        int drain;
        idle_send  = '{0, 84, 0, 8};
        idle_stall = '{0, 0, 84, 8};
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The clearing pass after reset shows up as input stall; drive_item waits it out.

        // Directed: reset state, bad identifiers on both commands.
        drive_item(make_frame(16'd0, 32'd0, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF));
        drive_item(make_frame(16'(C_ID_LIMIT), 32'd0, 1'b1, 4'd8, '1));
        drive_item(make_slot_write(16'hFFFF, MODE_ALWAYS, 16'd1, 16'd1));
        // Always mode: length extremes, overlong length, bytes beyond length zeroed.
        drive_item(make_slot_write(16'd5, MODE_ALWAYS, 16'd0, 16'd0));
        drive_item(make_frame(16'd5, 32'd0, 1'b0, 4'd0, '1));
        drive_item(make_frame(16'd5, 32'd1, 1'b1, 4'd8, '1));
        drive_item(make_frame(16'd5, 32'd2, 1'b0, 4'd15, 64'hFEDC_BA98_7654_3210));
        drive_item(make_frame(16'd5, 32'd3, 1'b1, 4'd3, 64'hFEDC_BA98_7654_3210));
        // Timed mode: equal elapsed time drops, one more forwards.
        drive_item(make_slot_write(16'd2047, MODE_TIMED, 16'd100, 16'd0));
        drive_item(make_frame(16'd2047, 32'd50, 1'b0, 4'd1, '1));
        drive_item(make_frame(16'd2047, 32'd100, 1'b0, 4'd1, '1));
        drive_item(make_frame(16'd2047, 32'd101, 1'b0, 4'd1, '1));
        drive_item(make_frame(16'd2047, 32'd201, 1'b0, 4'd1, '1));
        drive_item(make_frame(16'd2047, 32'd202, 1'b0, 4'd1, '1));
        // Timed mode across the 32-bit wrap with the largest period.
        drive_item(make_slot_write(16'd2046, MODE_TIMED, 16'hFFFF, 16'hFFFF));
        drive_item(make_frame(16'd2046, 32'hFFFF_FFFF, 1'b0, 4'd2, '1));
        drive_item(make_frame(16'd2046, 32'h0000_FFFE, 1'b0, 4'd2, '1));
        drive_item(make_frame(16'd2046, 32'h0000_FFFF, 1'b0, 4'd2, '1));
        // Count mode: zero count forwards every frame, count of three every third.
        drive_item(make_slot_write(16'd7, MODE_COUNT, 16'd0, 16'd0));
        drive_item(make_frame(16'd7, 32'd0, 1'b0, 4'd4, '1));
        drive_item(make_slot_write(16'd7, MODE_COUNT, 16'd0, 16'd3));
        repeat (3) drive_item(make_frame(16'd7, 32'd0, 1'b0, 4'd4, '1));
        // Never mode after a rewrite.
        drive_item(make_slot_write(16'd5, MODE_NEVER, 16'd0, 16'd0));
        drive_item(make_frame(16'd5, 32'd0, 1'b0, 4'd8, '1));

        // Random part in four traffic phases; the first also holds the output off for a while.
        hot_ids[0] = 16'd0;
        hot_ids[1] = 16'(C_ID_LIMIT - 1);
        for (int k = 2; k < 8; k++) hot_ids[k] = 16'($urandom_range(0, C_ID_LIMIT - 1));
        clock_ms = $urandom;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_send[p];
            stall_pct     = idle_stall[p];
            if (p == 0) hold_req_seq++;
            program_hot_slots();
            repeat (RANDOM_ITEMS / 4) drive_item(random_item());
        end
        i_in_valid <= 1'b0;
        stall_pct  = 0;

        // Drain outstanding results, then give the block a few idle cycles.
        drain = 0;
        while (sb.pending() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.error_count++;
            $display("ERROR: %0d results never arrived", sb.pending());
        end

        $display("Checked %0d forwarded, %0d dropped, %0d bad-ID and %0d slot-write results",
                 sb.status_seen[STAT_FORWARDED], sb.status_seen[STAT_DROPPED],
                 sb.status_seen[STAT_BAD_ID], sb.status_seen[STAT_WRITTEN]);
        $display("over four sender/receiver idle profiles and one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (sb.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the post-reset table clear.
    initial begin
        #2000000;
        $display("ERROR: timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
